// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker modules of the vertex transform.
// Self-contained: no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define AVT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define AVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define AVT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/avt2d_pkg.sv =====
// Package of the 2-D affine vertex transform: constants, mode and register codes,
// and the configuration struct. Depends on nothing.
`timescale 1ns / 1ps

package avt2d_pkg;

   localparam int COORD_WIDTH_DEF = 12;
   localparam int PIVOT_DEF       = 50;

   // Fixed widths of the configuration fields.
   localparam int MODE_W     = 3;
   localparam int COEF_W     = 16;
   localparam int SHIFT_W    = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Every sum is held in Q.14; Q4.12 terms are moved up by two places.
   localparam int FRAC_BITS  = 14;
   localparam int ALIGN_BITS = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_XSHEAR    = 3'd0,
      MODE_YSHEAR    = 3'd1,
      MODE_ROTATE    = 3'd2,
      MODE_TRANSLATE = 3'd3,
      MODE_SCALE     = 3'd4
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE    = 3'd0,
      CSR_SHEAR   = 3'd1,
      CSR_COS     = 3'd2,
      CSR_SIN     = 3'd3,
      CSR_SHIFT_X = 3'd4,
      CSR_SHIFT_Y = 3'd5,
      CSR_SCALE_X = 3'd6,
      CSR_SCALE_Y = 3'd7
   } csr_index_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [COEF_W-1:0]  shear_amount;
      logic signed [COEF_W-1:0]  cos_value;
      logic signed [COEF_W-1:0]  sin_value;
      logic signed [SHIFT_W-1:0] shift_x;
      logic signed [SHIFT_W-1:0] shift_y;
      logic signed [COEF_W-1:0]  scale_x;
      logic signed [COEF_W-1:0]  scale_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:         MODE_TRANSLATE,
      shear_amount: 16'sd0,
      cos_value:    16'sd16384,
      sin_value:    16'sd0,
      shift_x:      12'sd0,
      shift_y:      12'sd0,
      scale_x:      16'sd4096,
      scale_y:      16'sd4096
   };

endpackage

// ===== rtl/core/avt2d_csr.sv =====
// Configuration register file of the vertex transform.
// Depends on avt2d_pkg.
`timescale 1ns / 1ps

module avt2d_csr
   import avt2d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_MODE:    cfg_in.mode         = mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_SHEAR:   cfg_in.shear_amount = $signed(csr_wdata[COEF_W-1:0]);
            CSR_COS:     cfg_in.cos_value    = $signed(csr_wdata[COEF_W-1:0]);
            CSR_SIN:     cfg_in.sin_value    = $signed(csr_wdata[COEF_W-1:0]);
            CSR_SHIFT_X: cfg_in.shift_x      = $signed(csr_wdata[SHIFT_W-1:0]);
            CSR_SHIFT_Y: cfg_in.shift_y      = $signed(csr_wdata[SHIFT_W-1:0]);
            CSR_SCALE_X: cfg_in.scale_x      = $signed(csr_wdata[COEF_W-1:0]);
            CSR_SCALE_Y: cfg_in.scale_y      = $signed(csr_wdata[COEF_W-1:0]);
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/avt2d_operand.sv =====
// First pipeline stage: pivot offsets and selection of multiplier operands per mode.
// Depends on avt2d_pkg.
`timescale 1ns / 1ps

module avt2d_operand
   import avt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int PIVOT       = PIVOT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ax1,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ax2,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ay1,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ay2,
   output logic signed [COEF_W-1:0]      bx1,
   output logic signed [COEF_W-1:0]      bx2,
   output logic signed [COEF_W-1:0]      by1,
   output logic signed [COEF_W-1:0]      by2,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_x,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_y,
   output logic                          align
);

   // DW holds a coordinate plus a twelve-bit shift or pivot; AW also holds its negation.
   localparam int DW = ((COORD_WIDTH > SHIFT_W) ? COORD_WIDTH : SHIFT_W) + 1;
   localparam int AW = DW + 1;
   localparam logic signed [DW-1:0] PIVOT_V = DW'(PIVOT);

   logic signed [DW-1:0]     xs, ys, dx, dy;
   logic signed [AW-1:0]     ax1_in, ax2_in, ay1_in, ay2_in;
   logic signed [AW-1:0]     ax1_ff, ax2_ff, ay1_ff, ay2_ff;
   logic signed [COEF_W-1:0] bx1_in, bx2_in, by1_in, by2_in;
   logic signed [COEF_W-1:0] bx1_ff, bx2_ff, by1_ff, by2_ff;
   logic signed [DW-1:0]     base_x_in, base_y_in, base_x_ff, base_y_ff;
   logic                     align_in, align_ff;
   logic                     valid_ff;

   assign xs = DW'(in_x);
   assign ys = DW'(in_y);
   assign dx = xs - PIVOT_V;
   assign dy = ys - PIVOT_V;

   always_comb begin
      ax1_in    = '0;
      ax2_in    = '0;
      ay1_in    = '0;
      ay2_in    = '0;
      bx1_in    = '0;
      bx2_in    = '0;
      by1_in    = '0;
      by2_in    = '0;
      base_x_in = xs;
      base_y_in = ys;
      align_in  = 1'b1;
      case (cfg.mode)
         MODE_XSHEAR: begin
            ax1_in = AW'(dy);
            bx1_in = cfg.shear_amount;
         end
         MODE_YSHEAR: begin
            ay1_in = AW'(dx);
            by1_in = cfg.shear_amount;
         end
         MODE_ROTATE: begin
            ax1_in    = AW'(dx);
            bx1_in    = cfg.cos_value;
            ax2_in    = -AW'(dy);
            bx2_in    = cfg.sin_value;
            ay1_in    = AW'(dx);
            by1_in    = cfg.sin_value;
            ay2_in    = AW'(dy);
            by2_in    = cfg.cos_value;
            base_x_in = PIVOT_V;
            base_y_in = PIVOT_V;
            align_in  = 1'b0;
         end
         MODE_TRANSLATE: begin
            base_x_in = xs + DW'(cfg.shift_x);
            base_y_in = ys + DW'(cfg.shift_y);
         end
         MODE_SCALE: begin
            ax1_in    = AW'(xs);
            bx1_in    = cfg.scale_x;
            ay1_in    = AW'(ys);
            by1_in    = cfg.scale_y;
            base_x_in = '0;
            base_y_in = '0;
         end
         default: begin
            base_x_in = xs;
            base_y_in = ys;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ax1_ff    <= ax1_in;
         ax2_ff    <= ax2_in;
         ay1_ff    <= ay1_in;
         ay2_ff    <= ay2_in;
         bx1_ff    <= bx1_in;
         bx2_ff    <= bx2_in;
         by1_ff    <= by1_in;
         by2_ff    <= by2_in;
         base_x_ff <= base_x_in;
         base_y_ff <= base_y_in;
         align_ff  <= align_in;
      end
   end

   assign out_valid = valid_ff;
   assign ax1       = ax1_ff;
   assign ax2       = ax2_ff;
   assign ay1       = ay1_ff;
   assign ay2       = ay2_ff;
   assign bx1       = bx1_ff;
   assign bx2       = bx2_ff;
   assign by1       = by1_ff;
   assign by2       = by2_ff;
   assign base_x    = base_x_ff;
   assign base_y    = base_y_ff;
   assign align     = align_ff;

endmodule

// ===== rtl/core/avt2d_mult.sv =====
// Second pipeline stage: four registered signed multipliers.
// Depends on avt2d_pkg.
`timescale 1ns / 1ps

module avt2d_mult
   import avt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ax1,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ax2,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ay1,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+1:0] ay2,
   input  logic signed [COEF_W-1:0]      bx1,
   input  logic signed [COEF_W-1:0]      bx2,
   input  logic signed [COEF_W-1:0]      by1,
   input  logic signed [COEF_W-1:0]      by2,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_x,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_y,
   input  logic                          align,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] px1,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] px2,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] py1,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] py2,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_x_out,
   output logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_y_out,
   output logic                          align_out
);

   localparam int DW = ((COORD_WIDTH > SHIFT_W) ? COORD_WIDTH : SHIFT_W) + 1;
   localparam int AW = DW + 1;
   localparam int PW = AW + COEF_W;

   logic signed [PW-1:0] px1_in, px2_in, py1_in, py2_in;
   logic signed [PW-1:0] px1_ff, px2_ff, py1_ff, py2_ff;
   logic signed [DW-1:0] base_x_ff, base_y_ff;
   logic                 align_ff;
   logic                 valid_ff;

   assign px1_in = PW'(ax1) * PW'(bx1);
   assign px2_in = PW'(ax2) * PW'(bx2);
   assign py1_in = PW'(ay1) * PW'(by1);
   assign py2_in = PW'(ay2) * PW'(by2);

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         px1_ff    <= px1_in;
         px2_ff    <= px2_in;
         py1_ff    <= py1_in;
         py2_ff    <= py2_in;
         base_x_ff <= base_x;
         base_y_ff <= base_y;
         align_ff  <= align;
      end
   end

   assign out_valid  = valid_ff;
   assign px1        = px1_ff;
   assign px2        = px2_ff;
   assign py1        = py1_ff;
   assign py2        = py2_ff;
   assign base_x_out = base_x_ff;
   assign base_y_out = base_y_ff;
   assign align_out  = align_ff;

endmodule

// ===== rtl/core/avt2d_resolve.sv =====
// Third and fourth pipeline stages: Q.14 sum, then truncation toward zero and
// saturation into the output register. Depends on avt2d_pkg.
`timescale 1ns / 1ps

module avt2d_resolve
   import avt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] px1,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] px2,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] py1,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W)+COEF_W+1:0] py2,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_x,
   input  logic signed [((COORD_WIDTH>SHIFT_W)?COORD_WIDTH:SHIFT_W):0] base_y,
   input  logic                          align,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_x,
   output logic signed [COORD_WIDTH-1:0] out_y,
   output logic                          clipped
);

   localparam int DW = ((COORD_WIDTH > SHIFT_W) ? COORD_WIDTH : SHIFT_W) + 1;
   localparam int PW = DW + 1 + COEF_W;
   localparam int SW = PW + ALIGN_BITS + 2;
   localparam int QW = SW - FRAC_BITS;

   localparam logic signed [SW-1:0] ROUND_BIAS = SW'((1 << FRAC_BITS) - 1);
   localparam logic signed [SW-1:0] ZERO_SW    = '0;
   localparam logic signed [QW-1:0] SAT_HI     = QW'((1 << (COORD_WIDTH - 1)) - 1);
   localparam logic signed [QW-1:0] SAT_LO     = -QW'(1 << (COORD_WIDTH - 1));

   logic signed [SW-1:0]          prod_x, prod_y;
   logic signed [SW-1:0]          sum_x_in, sum_y_in, sum_x_ff, sum_y_ff;
   logic signed [SW-1:0]          adj_x, adj_y;
   logic signed [QW-1:0]          q_x, q_y;
   logic signed [COORD_WIDTH-1:0] out_x_in, out_y_in, out_x_ff, out_y_ff;
   logic                          clip_in, clip_ff;
   logic                          sum_valid_ff, out_valid_ff;
   logic                          sum_ready, out_slot_ready;

   // Stage three: base moved to Q.14, product pair moved up when it is Q4.12.
   assign prod_x   = SW'(px1) + SW'(px2);
   assign prod_y   = SW'(py1) + SW'(py2);
   assign sum_x_in = (SW'(base_x) <<< FRAC_BITS) + (align ? (prod_x <<< ALIGN_BITS) : prod_x);
   assign sum_y_in = (SW'(base_y) <<< FRAC_BITS) + (align ? (prod_y <<< ALIGN_BITS) : prod_y);

   // Stage four: a negative sum gets the bias so that the shift truncates toward zero.
   assign adj_x = sum_x_ff + (sum_x_ff[SW-1] ? ROUND_BIAS : ZERO_SW);
   assign adj_y = sum_y_ff + (sum_y_ff[SW-1] ? ROUND_BIAS : ZERO_SW);
   assign q_x   = $signed(adj_x[SW-1:FRAC_BITS]);
   assign q_y   = $signed(adj_y[SW-1:FRAC_BITS]);

   always_comb begin
      clip_in  = 1'b0;
      out_x_in = q_x[COORD_WIDTH-1:0];
      out_y_in = q_y[COORD_WIDTH-1:0];
      if (q_x > SAT_HI) begin
         out_x_in = SAT_HI[COORD_WIDTH-1:0];
         clip_in  = 1'b1;
      end else if (q_x < SAT_LO) begin
         out_x_in = SAT_LO[COORD_WIDTH-1:0];
         clip_in  = 1'b1;
      end
      if (q_y > SAT_HI) begin
         out_y_in = SAT_HI[COORD_WIDTH-1:0];
         clip_in  = 1'b1;
      end else if (q_y < SAT_LO) begin
         out_y_in = SAT_LO[COORD_WIDTH-1:0];
         clip_in  = 1'b1;
      end
   end

   assign out_slot_ready = !out_valid_ff || out_ready;
   assign sum_ready      = !sum_valid_ff || out_slot_ready;
   assign in_ready       = sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (sum_ready) begin
            sum_valid_ff <= in_valid;
         end
         if (out_slot_ready) begin
            out_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && sum_ready) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
      if (sum_valid_ff && out_slot_ready) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         clip_ff  <= clip_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign clipped   = clip_ff;

endmodule

// ===== rtl/core/affine_vertex_transform_2d.sv =====
// Top level of the 2-D affine vertex transform: register file and four-stage pipeline.
// Depends on avt2d_pkg, avt2d_csr, avt2d_operand, avt2d_mult and avt2d_resolve.
//
//   Channel    Direction  Handshake              Contents
//   req_       in         req_tvalid/req_tready  one vertex per beat
//   rsp_       out        rsp_tvalid/rsp_tready  one transformed vertex per beat
//   csr_       in         csr_wr_en              register writes, no read-back
//
// One beat is taken every cycle while the result side takes beats. An accepted vertex
// passes through the four pipeline registers (operands, products, Q.14 sum, saturated
// result) before it is shown on the result side and can leave.
// Reset is synchronous and active high; it empties the pipeline and loads the
// register defaults (translate mode, zero shifts, unit scale, zero-degree rotation).
// Each stage holds its beat while the stage after it is full and stalled, and takes
// a new one as soon as it empties, so bubbles close up and nothing is lost or sent twice.
`timescale 1ns / 1ps

module affine_vertex_transform_2d
   import avt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int PIVOT       = PIVOT_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Vertex input. tdata from bit 0: vertex_x, vertex_y, zero padding.
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   // Result output. tdata from bit 0: out_x, out_y, clipped, zero padding.
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]     rsp_tdata,
   // Register write port.
   input  logic                                     csr_wr_en,
   input  logic [CSR_ADDR_W-1:0]                    csr_addr,
   input  logic [CSR_DATA_W-1:0]                    csr_wdata
);

   localparam int DW     = ((COORD_WIDTH > SHIFT_W) ? COORD_WIDTH : SHIFT_W) + 1;
   localparam int AW     = DW + 1;
   localparam int PW     = AW + COEF_W;
   localparam int OUT_TW = ((2 * COORD_WIDTH + 1 + 7) / 8) * 8;

   cfg_type cfg;

   logic signed [COORD_WIDTH-1:0] vertex_x, vertex_y;
   logic signed [COORD_WIDTH-1:0] out_x, out_y;
   logic                          clipped;

   // Stage one to stage two.
   logic                     op_valid, op_ready;
   logic signed [AW-1:0]     ax1, ax2, ay1, ay2;
   logic signed [COEF_W-1:0] bx1, bx2, by1, by2;
   logic signed [DW-1:0]     op_base_x, op_base_y;
   logic                     op_align;

   // Stage two to stage three.
   logic                 mul_valid, mul_ready;
   logic signed [PW-1:0] px1, px2, py1, py2;
   logic signed [DW-1:0] mul_base_x, mul_base_y;
   logic                 mul_align;

   assign vertex_x = $signed(req_tdata[COORD_WIDTH-1:0]);
   assign vertex_y = $signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

   avt2d_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The user must change the registers only while the pipeline is empty; the block does
   // not enforce this. The operand stage alone reads them, directly.
   avt2d_operand #(
      .COORD_WIDTH (COORD_WIDTH),
      .PIVOT       (PIVOT)
   ) u_operand (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (vertex_x),
      .in_y      (vertex_y),
      .out_valid (op_valid),
      .out_ready (op_ready),
      .ax1       (ax1),
      .ax2       (ax2),
      .ay1       (ay1),
      .ay2       (ay2),
      .bx1       (bx1),
      .bx2       (bx2),
      .by1       (by1),
      .by2       (by2),
      .base_x    (op_base_x),
      .base_y    (op_base_y),
      .align     (op_align)
   );

   avt2d_mult #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (op_valid),
      .in_ready   (op_ready),
      .ax1        (ax1),
      .ax2        (ax2),
      .ay1        (ay1),
      .ay2        (ay2),
      .bx1        (bx1),
      .bx2        (bx2),
      .by1        (by1),
      .by2        (by2),
      .base_x     (op_base_x),
      .base_y     (op_base_y),
      .align      (op_align),
      .out_valid  (mul_valid),
      .out_ready  (mul_ready),
      .px1        (px1),
      .px2        (px2),
      .py1        (py1),
      .py2        (py2),
      .base_x_out (mul_base_x),
      .base_y_out (mul_base_y),
      .align_out  (mul_align)
   );

   avt2d_resolve #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .px1       (px1),
      .px2       (px2),
      .py1       (py1),
      .py2       (py2),
      .base_x    (mul_base_x),
      .base_y    (mul_base_y),
      .align     (mul_align),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (out_x),
      .out_y     (out_y),
      .clipped   (clipped)
   );

   assign rsp_tdata = OUT_TW'({clipped, out_y, out_x});

endmodule

// ===== rtl/core/avt2d_checker.sv =====
// Port-level checker for the vertex transform, bound to the top level.
// Depends on avt2d_pkg, assert_macros.svh and affine_vertex_transform_2d.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module avt2d_checker
   import avt2d_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);

   localparam logic [COORD_WIDTH-1:0] SAT_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [COORD_WIDTH-1:0] rsp_x, rsp_y;
   logic                   rsp_clip;
   logic                   rsp_stall, rsp_clip_shown, on_bound;

   assign rsp_x    = rsp_tdata[COORD_WIDTH-1:0];
   assign rsp_y    = rsp_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign rsp_clip = rsp_tdata[2*COORD_WIDTH];

   assign rsp_stall      = rsp_tvalid && !rsp_tready;
   assign rsp_clip_shown = rsp_tvalid && rsp_clip;
   assign on_bound       = (rsp_x == SAT_HI) || (rsp_x == SAT_LO) ||
                           (rsp_y == SAT_HI) || (rsp_y == SAT_LO);

   // A stalled result beat stays offered and keeps its contents.
   `AVT_ASSERT_NEXT(a_rsp_keep, clock, reset, rsp_stall, rsp_tvalid, "stalled beat dropped")
   `AVT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_tdata), "beat changed")

   // A clipped result has at least one coordinate sitting on a range bound.
   `AVT_ASSERT_IMP(a_clip_bound, clock, reset, rsp_clip_shown, on_bound, "clip without bound")

   // With the result side taking beats, no stage can be blocked.
   `AVT_ASSERT_IMP(a_ready_flow, clock, reset, rsp_tready, req_tready, "input blocked")

   // Reset empties the pipeline.
   `AVT_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "beat after reset")

endmodule

bind affine_vertex_transform_2d avt2d_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_avt2d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_affine_vertex_transform_2d.sv =====
// Self-checking testbench of the 2-D affine vertex transform: directed and random vertex
// beats under many register settings, checked against a predictor kept in this file.
// Depends on avt2d_pkg and affine_vertex_transform_2d.
`timescale 1ns / 1ps

module tb_affine_vertex_transform_2d;
   import avt2d_pkg::*;

   localparam int CW         = COORD_WIDTH_DEF;
   localparam int PIVOT_POS  = PIVOT_DEF;
   localparam int REQ_W      = ((2*CW+7)/8)*8;
   localparam int RSP_W      = ((2*CW+1+7)/8)*8;
   localparam int COORD_MAX  = (1 << (CW-1)) - 1;
   localparam int COORD_MIN  = -(1 << (CW-1));
   localparam longint Q12_ONE = 4096;
   localparam longint Q14_ONE = 16384;

   // Mode codes that the block does not define; a vertex passes through unchanged.
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   // Cycles allowed for the pipeline to empty after the last expected result.
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 34;
   localparam int PHASE_ITEMS   = 50;
   localparam int MAX_ERRORS_SHOWN = 10;

   typedef struct packed {
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] x;
   } vertex_type;

   typedef struct packed {
      logic                 clipped;
      logic signed [CW-1:0] out_y;
      logic signed [CW-1:0] out_x;
   } moved_vertex_type;

   // Every input is given a known value from time zero.
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // The testbench's own copy of the register file, updated as each write is issued.
   cfg_type model_cfg = CFG_RESET;

   vertex_type       vertex_queue[$];
   moved_vertex_type expected_vertices[$];
   vertex_type       next_vertex;

   int  error_count = 0;
   int  beats_in    = 0;
   int  beats_out   = 0;
   int  clipped_seen = 0;
   int  mode_hits[8];
   bit  steady_run  = 1'b0;

   affine_vertex_transform_2d DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // from bit 0: vertex_x, vertex_y, zero padding
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // from bit 0: out_x, out_y, clipped, zero padding
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out where the current register setting sends one vertex. All products are
   // exact in 64 bits; the division truncates toward zero, as the block must.
   function automatic moved_vertex_type transform_vertex(input logic signed [CW-1:0] vx,
                                                         input logic signed [CW-1:0] vy);
      longint x, y, dx, dy, k, c, s, rx, ry;
      moved_vertex_type r;
      x  = longint'(vx);
      y  = longint'(vy);
      dx = x - longint'(PIVOT_POS);
      dy = y - longint'(PIVOT_POS);
      k  = longint'(model_cfg.shear_amount);
      c  = longint'(model_cfg.cos_value);
      s  = longint'(model_cfg.sin_value);
      rx = x;
      ry = y;
      case (model_cfg.mode)
         MODE_XSHEAR: begin
            rx = (x * Q12_ONE + k * dy) / Q12_ONE;
         end
         MODE_YSHEAR: begin
            ry = (y * Q12_ONE + k * dx) / Q12_ONE;
         end
         MODE_ROTATE: begin
            rx = (dx * c - dy * s + longint'(PIVOT_POS) * Q14_ONE) / Q14_ONE;
            ry = (dx * s + dy * c + longint'(PIVOT_POS) * Q14_ONE) / Q14_ONE;
         end
         MODE_TRANSLATE: begin
            rx = x + longint'(model_cfg.shift_x);
            ry = y + longint'(model_cfg.shift_y);
         end
         MODE_SCALE: begin
            rx = (x * longint'(model_cfg.scale_x)) / Q12_ONE;
            ry = (y * longint'(model_cfg.scale_y)) / Q12_ONE;
         end
         default: begin
            // Spare codes leave the vertex where it is.
         end
      endcase
      r.clipped = 1'b0;
      if (rx > longint'(COORD_MAX)) begin
         rx = longint'(COORD_MAX);
         r.clipped = 1'b1;
      end else if (rx < longint'(COORD_MIN)) begin
         rx = longint'(COORD_MIN);
         r.clipped = 1'b1;
      end
      if (ry > longint'(COORD_MAX)) begin
         ry = longint'(COORD_MAX);
         r.clipped = 1'b1;
      end else if (ry < longint'(COORD_MIN)) begin
         ry = longint'(COORD_MIN);
         r.clipped = 1'b1;
      end
      r.out_x = rx[CW-1:0];
      r.out_y = ry[CW-1:0];
      return r;
   endfunction

   // Driver. A beat is offered from the queue whenever the previous one has gone or
   // none was held; about a quarter of the chances are let pass, save in a steady run.
   // The expected result is worked out at the edge at which the beat is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_vertices.push_back(transform_vertex(req_tdata[CW-1:0],
                                                         req_tdata[2*CW-1:CW]));
            mode_hits[model_cfg.mode]++;
            beats_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (vertex_queue.size() > 0 && (steady_run || $urandom_range(99) >= 25)) begin
               next_vertex = vertex_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_W-2*CW){1'b0}}, next_vertex.y, next_vertex.x};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Compares one result beat, field by field, with the oldest expectation.
   task automatic check_vertex(input logic [RSP_W-1:0] beat);
      moved_vertex_type want;
      moved_vertex_type got;
      got = beat[2*CW:0];
      beats_out++;
      if (got.clipped) clipped_seen++;
      if (expected_vertices.size() == 0) begin
         error_count++;
         if (error_count <= MAX_ERRORS_SHOWN)
            $display("%0t: result beat x=%0d y=%0d clipped=%0b arrived with none expected",
                     $time, got.out_x, got.out_y, got.clipped);
      end else begin
         want = expected_vertices.pop_front();
         if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
             got.clipped !== want.clipped) begin
            error_count++;
            if (error_count <= MAX_ERRORS_SHOWN)
               $display("%0t: result beat %0d: expected x=%0d y=%0d clipped=%0b,",
                        $time, beats_out, want.out_x, want.out_y, want.clipped,
                        " got x=%0d y=%0d clipped=%0b",
                        got.out_x, got.out_y, got.clipped);
         end
      end
   endtask

   // Monitor. The result side stalls at random in about a quarter of the cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_run || ($urandom_range(99) >= 25);
         if (rsp_tvalid && rsp_tready) check_vertex(rsp_tdata);
      end
   end

   // The copy used for prediction changes as each register write is issued.
   // Writes are only issued while the block is idle, so no beat in flight sees it.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MODE:    model_cfg.mode         = mode_type'(value[MODE_W-1:0]);
         CSR_SHEAR:   model_cfg.shear_amount = value;
         CSR_COS:     model_cfg.cos_value    = value;
         CSR_SIN:     model_cfg.sin_value    = value;
         CSR_SHIFT_X: model_cfg.shift_x      = value[SHIFT_W-1:0];
         CSR_SHIFT_Y: model_cfg.shift_y      = value[SHIFT_W-1:0];
         CSR_SCALE_X: model_cfg.scale_x      = value;
         CSR_SCALE_Y: model_cfg.scale_y      = value;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_vertex(input int x, input int y);
      vertex_type v;
      v.x = CW'(x);
      v.y = CW'(y);
      vertex_queue.push_back(v);
   endtask

   // Waits, polling on the falling edge so as not to race the clocked blocks, until
   // every queued beat has been taken and every result has come back, then lets the
   // pipeline run empty before any register is touched.
   task automatic settle();
      while (vertex_queue.size() > 0 || req_tvalid || expected_vertices.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Coefficients: often an extreme, zero or unit, at times within plus and minus 8192, otherwise any sixteen bits.
   function automatic logic [CSR_DATA_W-1:0] pick_coef();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'h1000;
         4, 5:    return 16'($signed($urandom_range(16384)) - 8192);
         default: return 16'($urandom);
      endcase
   endfunction

   // Sine and cosine: mostly within plus and minus one in Q2.14, at times any value.
   function automatic logic [CSR_DATA_W-1:0] pick_trig();
      case ($urandom_range(9))
         0:       return 16'hC000;
         1:       return 16'h4000;
         2:       return 16'h0000;
         3:       return 16'($urandom);
         default: return 16'($signed($urandom_range(32768)) - 16384);
      endcase
   endfunction

   // Coordinates: extremes, the pivot, values near the origin, or any twelve bits.
   function automatic int pick_coord();
      case ($urandom_range(9))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return PIVOT_POS;
         3, 4:    return int'($urandom_range(400)) - 200;
         default: return int'($signed(CW'($urandom)));
      endcase
   endfunction

   // A fresh setting: always a mode, mostly a defined one; the other registers
   // are rewritten with an even chance each, so earlier values also carry over.
   task automatic random_setting();
      if ($urandom_range(9) < 8)
         write_reg(CSR_MODE, CSR_DATA_W'($urandom_range(MODE_SCALE, MODE_XSHEAR)));
      else
         write_reg(CSR_MODE, CSR_DATA_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST)));
      if ($urandom_range(1)) write_reg(CSR_SHEAR, pick_coef());
      if ($urandom_range(1)) write_reg(CSR_COS, pick_trig());
      if ($urandom_range(1)) write_reg(CSR_SIN, pick_trig());
      // Shifts are twelve bits wide; the upper bits of the write data must be dropped.
      if ($urandom_range(1)) write_reg(CSR_SHIFT_X, 16'($urandom));
      if ($urandom_range(1)) write_reg(CSR_SHIFT_Y, 16'($urandom));
      if ($urandom_range(1)) write_reg(CSR_SCALE_X, pick_coef());
      if ($urandom_range(1)) write_reg(CSR_SCALE_Y, pick_coef());
      end_writes();
   endtask

   initial begin : stimulus
      int waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: translation by zero, so the extremes come back untouched.
      push_vertex(COORD_MIN, COORD_MIN);
      push_vertex(COORD_MAX, COORD_MAX);
      push_vertex(0, 0);
      settle();

      // Translation by the largest shifts; the first vertex saturates both coordinates, the second does not.
      write_reg(CSR_SHIFT_X, 16'h07FF);
      write_reg(CSR_SHIFT_Y, 16'hF800);
      end_writes();
      push_vertex(COORD_MAX, COORD_MIN);
      push_vertex(COORD_MIN, COORD_MAX);
      settle();

      // Largest positive x-shear; the pivot itself must not move.
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_XSHEAR));
      write_reg(CSR_SHEAR, 16'h7FFF);
      end_writes();
      push_vertex(0, COORD_MIN);
      push_vertex(0, COORD_MAX);
      push_vertex(PIVOT_POS, PIVOT_POS);
      settle();

      // Most negative y-shear.
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_YSHEAR));
      write_reg(CSR_SHEAR, 16'h8000);
      end_writes();
      push_vertex(COORD_MIN, 0);
      push_vertex(COORD_MAX, 5);
      settle();

      // Quarter turn about the pivot.
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_ROTATE));
      write_reg(CSR_COS, 16'h0000);
      write_reg(CSR_SIN, 16'h4000);
      end_writes();
      push_vertex(100, PIVOT_POS);
      push_vertex(COORD_MIN, COORD_MAX);
      settle();

      // Half turn, then a cosine and sine beyond unit size, taken as their bits say.
      write_reg(CSR_COS, 16'hC000);
      write_reg(CSR_SIN, 16'h0000);
      end_writes();
      push_vertex(51, 49);
      settle();
      write_reg(CSR_COS, 16'h7FFF);
      write_reg(CSR_SIN, 16'h8000);
      end_writes();
      push_vertex(COORD_MAX, COORD_MIN);
      push_vertex(-1, 1);
      settle();

      // Scaling by the extreme factors; small negative products must truncate toward zero.
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_SCALE));
      write_reg(CSR_SCALE_X, 16'h7FFF);
      write_reg(CSR_SCALE_Y, 16'h8000);
      end_writes();
      push_vertex(-1, 1);
      push_vertex(3, -3);
      push_vertex(COORD_MAX, COORD_MIN);
      settle();
      write_reg(CSR_SCALE_X, 16'h0800);
      write_reg(CSR_SCALE_Y, 16'h0800);
      end_writes();
      push_vertex(-1, -3);
      settle();

      // Each spare mode code lets the vertex through.
      for (int m = int'(MODE_SPARE_FIRST); m <= int'(MODE_SPARE_LAST); m++) begin
         write_reg(CSR_MODE, CSR_DATA_W'(m));
         end_writes();
         push_vertex(COORD_MAX, COORD_MIN);
         settle();
      end

      // Random part: a new setting per phase, a steady run without stalls in the middle.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady_run = (p >= 12 && p < 17);
         random_setting();
         for (int i = 0; i < PHASE_ITEMS; i++)
            push_vertex(pick_coord(), pick_coord());
         if (p < RANDOM_PHASES - 1) settle();
      end
      steady_run = 1'b0;

      // Final drain, bounded; anything still expected afterwards is a failure.
      waited = 0;
      while ((vertex_queue.size() > 0 || req_tvalid || expected_vertices.size() > 0) &&
             waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_vertices.size() > 0) begin
         $display("%0d expected result beats never arrived", expected_vertices.size());
         error_count += expected_vertices.size();
      end

      $display("Run covered %0d vertex beats in and %0d result beats out, %0d clipped.",
               beats_in, beats_out, clipped_seen);
      $display("Beats per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; %0d mismatches.",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
               mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7], error_count);
      if (error_count == 0) begin
         $display("affine_vertex_transform_2d verification clean");
      end else begin
         $display("affine_vertex_transform_2d verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("affine_vertex_transform_2d verification failed");
      $finish;
   end

endmodule
